@@ rtl/core/distinct_word_char_max_count_top_assert.svh @@
// assertion macros shared by the rtl files of the distinct word counter
`ifndef DISTINCT_WORD_CHAR_MAX_COUNT_TOP_ASSERT_SVH
`define DISTINCT_WORD_CHAR_MAX_COUNT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define DWC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`define DWC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define DWC_ASSERT_SAME(label, clk, rstn, ante, cons)

`define DWC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/core/dwc_pkg.sv @@
// package with constants and types of the distinct word counter
`timescale 1ns / 1ps

package dwc_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int COUNT_BITS    = 16;
    localparam int BYTE_W        = 8;
    localparam int OUT_W         = 16;
    localparam int ADDR_W        = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [OUT_W-1:0]      out_count_t;

    localparam count_t     COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam out_count_t OUT_MAX   = {OUT_W{1'b1}};

    typedef struct packed {
        count_t count;
        count_t last;
    } entry_t;

    typedef struct packed {
        logic   valid;
        addr_t  addr;
        count_t word_idx;
        logic   clear;
    } tally_req_t;

    typedef struct packed {
        count_t running_max;
        logic   count_ovf;
        logic   busy;
    } tally_stat_t;

endpackage

@@ rtl/core/dwc_data_if.sv @@
// input channel carrying one byte of the word list
`timescale 1ns / 1ps

interface dwc_data_if
    import dwc_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink (input valid, input byte_value, output ready);
endinterface

@@ rtl/core/dwc_result_if.sv @@
// output channel carrying the largest word count and overflow
`timescale 1ns / 1ps

interface dwc_result_if
    import dwc_pkg::*;
;
    logic       valid;
    logic       ready;
    out_count_t max_word_count;
    logic       overflow;

    modport source (output valid, output max_word_count, output overflow, input ready);
    modport sink (input valid, input max_word_count, input overflow, output ready);
endinterface

@@ rtl/core/dwc_tally.sv @@
// per byte value count store with read-modify-write, forwarding and running maximum
`timescale 1ns / 1ps
`include "distinct_word_char_max_count_top_assert.svh"

module dwc_tally
    import dwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tally_req_t  req,
    output tally_stat_t stat
);

    entry_t mem [ALPHABET_SIZE];

    logic [ALPHABET_SIZE-1:0] seen_reg, seen_next;
    logic   s1_valid_reg;
    addr_t  s1_addr_reg;
    count_t s1_word_reg;
    entry_t rd_data_reg;
    logic   fwd_valid_reg;
    addr_t  fwd_addr_reg;
    entry_t fwd_data_reg;
    count_t running_max_reg, running_max_next;

    entry_t entry_cur;
    entry_t entry_new;
    logic   seen_cur;
    logic   fresh;
    logic   sat;
    logic   wr_en;
    count_t old_count;
    count_t new_count;

    // read issued in the cycle of the transaction
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rd_data_reg <= mem[req.addr];
        end
        if (wr_en)
        begin
            mem[s1_addr_reg] <= entry_new;
        end
    end

    always_comb
    begin
        entry_cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data_reg;
        seen_cur  = seen_reg[s1_addr_reg];
        fresh     = !seen_cur || (entry_cur.last != s1_word_reg);
        old_count = seen_cur ? entry_cur.count : '0;
        sat       = (old_count == COUNT_MAX);
        new_count = sat ? old_count : old_count + count_t'(1);
        wr_en     = s1_valid_reg && fresh;
        entry_new.count = new_count;
        entry_new.last  = s1_word_reg;

        seen_next = seen_reg;
        if (wr_en)
        begin
            seen_next[s1_addr_reg] = 1'b1;
        end
        if (req.clear)
        begin
            seen_next = '0;
        end

        running_max_next = running_max_reg;
        if (wr_en && (new_count > running_max_reg))
        begin
            running_max_next = new_count;
        end
        if (req.clear)
        begin
            running_max_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            running_max_reg <= '0;
        end
        else
        begin
            seen_reg        <= seen_next;
            s1_valid_reg    <= req.valid;
            fwd_valid_reg   <= wr_en && !req.clear;
            running_max_reg <= running_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= req.addr;
        s1_word_reg  <= req.word_idx;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= entry_new;
    end

    assign stat.running_max = running_max_reg;
    assign stat.count_ovf   = wr_en && sat;
    assign stat.busy        = s1_valid_reg;

    `DWC_ASSERT_NEXT(a_max_covers_write, clk, rst_n, wr_en && !req.clear,
        running_max_reg >= $past(new_count))
    `DWC_ASSERT_NEXT(a_seen_after_write, clk, rst_n, wr_en && !req.clear,
        seen_reg[$past(s1_addr_reg)])
    `DWC_ASSERT_NEXT(a_clear_empties, clk, rst_n, req.clear,
        (running_max_reg == '0) && (seen_reg == '0) && !fwd_valid_reg)

endmodule

@@ rtl/core/distinct_word_char_max_count_top.sv @@
// a result is registered and appears in the cycle after the ending double zero is taken
// throughput: one byte per cycle; a read-modify-write pipeline on the count memory
// with forwarding from the write just done keeps repeated bytes at full rate
// a result still held at the output stalls only the ending zero of the next list
// the end of a list clears all the valid flags together, so no clearing pass is needed
// reset: rst_n asynchronous, active low, empties the list and the output register
`timescale 1ns / 1ps
`include "distinct_word_char_max_count_top_assert.svh"

module distinct_word_char_max_count_top
    import dwc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    dwc_data_if.sink    data,
    dwc_result_if.source result
);

    logic   prev_zero_reg, prev_zero_next;
    count_t word_number_reg, word_number_next;
    logic   overflow_reg, overflow_next;
    logic   out_valid_reg;
    out_count_t out_max_reg;
    logic   out_ovf_reg;

    logic accept;
    logic is_zero;
    logic end_acc;
    logic in_alpha;
    logic word_sat;
    logic [31:0] run_wide;

    tally_req_t  req;
    tally_stat_t stat;

    assign is_zero    = (data.byte_value == '0);
    assign data.ready = !out_valid_reg || result.ready || !(is_zero && prev_zero_reg);
    assign accept     = data.valid && data.ready;
    assign end_acc    = accept && is_zero && prev_zero_reg;
    assign in_alpha   = ({1'b0, data.byte_value} < (BYTE_W+1)'(ALPHABET_SIZE));
    assign run_wide   = 32'(stat.running_max);

    always_comb
    begin
        prev_zero_next   = prev_zero_reg;
        word_number_next = word_number_reg;
        word_sat         = 1'b0;
        if (accept)
        begin
            if (is_zero)
            begin
                prev_zero_next = 1'b1;
            end
            else
            begin
                prev_zero_next = 1'b0;
                if (prev_zero_reg)
                begin
                    if (word_number_reg == COUNT_MAX)
                    begin
                        word_sat = 1'b1;
                    end
                    else
                    begin
                        word_number_next = word_number_reg + count_t'(1);
                    end
                end
            end
        end
        overflow_next = overflow_reg || word_sat || stat.count_ovf;
        if (end_acc)
        begin
            prev_zero_next   = 1'b0;
            word_number_next = '0;
            overflow_next    = 1'b0;
        end
    end

    assign req.valid    = accept && !is_zero && in_alpha;
    assign req.addr     = data.byte_value[ADDR_W-1:0];
    assign req.word_idx = word_number_next;
    assign req.clear    = end_acc;

    dwc_tally u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_zero_reg   <= 1'b0;
            word_number_reg <= '0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_zero_reg   <= prev_zero_next;
            word_number_reg <= word_number_next;
            overflow_reg    <= overflow_next;
            if (end_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_acc)
        begin
            out_max_reg <= (run_wide > 32'(OUT_MAX)) ? OUT_MAX : run_wide[OUT_W-1:0];
            out_ovf_reg <= overflow_reg || stat.count_ovf;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.max_word_count = out_max_reg;
    assign result.overflow       = out_ovf_reg;

    `DWC_ASSERT_SAME(a_pipe_idle_at_end, clk, rst_n, end_acc, !stat.busy)
    `DWC_ASSERT_NEXT(a_list_cleared, clk, rst_n, end_acc,
        (word_number_reg == '0) && !overflow_reg && !prev_zero_reg)
    `DWC_ASSERT_SAME(a_result_from_end, clk, rst_n, $rose(out_valid_reg),
        $past(end_acc))

endmodule
